// ===== src/lra_pkg.sv =====
package lra_pkg;

  localparam int COORD_WIDTH        = 24;
  localparam int AFFINITY_FRAC_BITS = 16;
  localparam int FRAC_W             = 16;
  localparam int MINTOL_W           = 24;

  localparam int DW    = COORD_WIDTH + 1;
  localparam int RW    = DW;
  localparam int SUMW  = 2 * DW;
  localparam int DOTW  = 2 * DW + 1;
  localparam int TW    = (DW > MINTOL_W) ? DW : MINTOL_W;
  localparam int DENW  = DW + TW;
  localparam int EW    = ((SUMW > DENW) ? SUMW : DENW) + 1;
  localparam int QW    = AFFINITY_FRAC_BITS;
  localparam int AFW   = AFFINITY_FRAC_BITS + 1;
  localparam int CFG_DATA_W = (COORD_WIDTH > MINTOL_W) ? COORD_WIDTH : MINTOL_W;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOL_FRAC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TOL  = 3'd4;

  localparam logic [FRAC_W-1:0]   TOL_FRAC_RESET = 16'd6554;
  localparam logic [MINTOL_W-1:0] MIN_TOL_RESET  = 24'd128;

endpackage

// ===== src/lra_sqrt_pipe.sv =====
module lra_sqrt_pipe (
  input  logic                       clk,
  input  logic                       en,
  input  logic [lra_pkg::SUMW-1:0]   x_in,
  output logic [lra_pkg::RW-1:0]     root
);
  import lra_pkg::*;

  logic [SUMW-1:0] x_r   [RW];
  logic [SUMW-1:0] res_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam logic [SUMW-1:0] ONE = SUMW'(1) << (2 * (RW - 1 - k));
    logic [SUMW-1:0] x_cur, res_cur, trial, x_nxt, res_nxt;

    if (k == 0) begin : g_first
      assign x_cur   = x_in;
      assign res_cur = '0;
    end else begin : g_rest
      assign x_cur   = x_r[k-1];
      assign res_cur = res_r[k-1];
    end

    always_comb begin
      trial = res_cur + ONE;
      if (x_cur >= trial) begin
        x_nxt   = x_cur - trial;
        res_nxt = (res_cur >> 1) + ONE;
      end else begin
        x_nxt   = x_cur;
        res_nxt = res_cur >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]   <= x_nxt;
        res_r[k] <= res_nxt;
      end
    end
  end

  assign root = res_r[RW-1][RW-1:0];

endmodule

// ===== src/lra_div_pipe.sv =====
module lra_div_pipe (
  input  logic                     clk,
  input  logic                     en,
  input  logic [lra_pkg::EW-1:0]   num_in,
  input  logic [lra_pkg::EW-1:0]   den_in,
  output logic                     ge,
  output logic [lra_pkg::QW-1:0]   quo
);
  import lra_pkg::*;

  logic [EW-1:0] r_r   [QW+1];
  logic [EW-1:0] d_r   [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic          ge_r  [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]  <= num_in;
      d_r[0]  <= den_in;
      q_r[0]  <= '0;
      ge_r[0] <= (num_in >= den_in);
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [EW-1:0] sh;
    logic [EW-1:0] r_nxt;
    logic          bit_nxt;

    always_comb begin
      sh = {r_r[k-1][EW-2:0], 1'b0};
      if (sh >= d_r[k-1]) begin
        r_nxt   = sh - d_r[k-1];
        bit_nxt = 1'b1;
      end else begin
        r_nxt   = sh;
        bit_nxt = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]  <= r_nxt;
        d_r[k]  <= d_r[k-1];
        q_r[k]  <= {q_r[k-1][QW-2:0], bit_nxt};
        ge_r[k] <= ge_r[k-1];
      end
    end
  end

  assign ge  = ge_r[QW];
  assign quo = q_r[QW];

endmodule

// ===== src/localization_range_affinity_core.sv =====
// throughput: one request per cycle, set by the bit-per-stage square root
//   and divider pipelines; the whole pipeline halts while the output is stalled
// reset: synchronous active-low rst_n clears valid bits and loads register
//   defaults (sensor at origin, fraction 6554, minimum tolerance 128)
module localization_range_affinity_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [lra_pkg::COORD_WIDTH-1:0]  in_pred_x,
  input  logic signed [lra_pkg::COORD_WIDTH-1:0]  in_pred_y,
  input  logic signed [lra_pkg::COORD_WIDTH-1:0]  in_pred_z,
  input  logic signed [lra_pkg::COORD_WIDTH-1:0]  in_truth_x,
  input  logic signed [lra_pkg::COORD_WIDTH-1:0]  in_truth_y,
  input  logic signed [lra_pkg::COORD_WIDTH-1:0]  in_truth_z,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [lra_pkg::AFW-1:0]                 out_affinity,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [lra_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [lra_pkg::CFG_DATA_W-1:0]          cfg_data
);
  import lra_pkg::*;

  localparam int LAT = 3 + RW + 4 + (QW + 1) + 1;

  logic signed [COORD_WIDTH-1:0] sx_r, sy_r, sz_r;
  logic [FRAC_W-1:0]             frac_r;
  logic [MINTOL_W-1:0]           mint_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r   <= '0;
      sy_r   <= '0;
      sz_r   <= '0;
      frac_r <= TOL_FRAC_RESET;
      mint_r <= MIN_TOL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SENSOR_X: sx_r   <= cfg_data[COORD_WIDTH-1:0];
        REG_SENSOR_Y: sy_r   <= cfg_data[COORD_WIDTH-1:0];
        REG_SENSOR_Z: sz_r   <= cfg_data[COORD_WIDTH-1:0];
        REG_TOL_FRAC: frac_r <= cfg_data[FRAC_W-1:0];
        REG_MIN_TOL:  mint_r <= cfg_data[MINTOL_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic vld_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // sensor frame offsets
  logic signed [DW-1:0] pd1_r [3];
  logic signed [DW-1:0] gd1_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      pd1_r[0] <= DW'(in_pred_x)  - DW'(sx_r);
      pd1_r[1] <= DW'(in_pred_y)  - DW'(sy_r);
      pd1_r[2] <= DW'(in_pred_z)  - DW'(sz_r);
      gd1_r[0] <= DW'(in_truth_x) - DW'(sx_r);
      gd1_r[1] <= DW'(in_truth_y) - DW'(sy_r);
      gd1_r[2] <= DW'(in_truth_z) - DW'(sz_r);
    end
  end

  // products
  logic signed [2*DW-1:0] psq2_r [3];
  logic signed [2*DW-1:0] gsq2_r [3];
  logic signed [2*DW-1:0] pg2_r  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        psq2_r[i] <= pd1_r[i] * pd1_r[i];
        gsq2_r[i] <= gd1_r[i] * gd1_r[i];
        pg2_r[i]  <= pd1_r[i] * gd1_r[i];
      end
    end
  end

  // sums
  logic [SUMW-1:0]        sp3_r, sg3_r;
  logic signed [DOTW-1:0] dot3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sp3_r  <= SUMW'(psq2_r[0]) + SUMW'(psq2_r[1]) + SUMW'(psq2_r[2]);
      sg3_r  <= SUMW'(gsq2_r[0]) + SUMW'(gsq2_r[1]) + SUMW'(gsq2_r[2]);
      dot3_r <= DOTW'(pg2_r[0]) + DOTW'(pg2_r[1]) + DOTW'(pg2_r[2]);
    end
  end

  logic [RW-1:0] pr_root, gt_root;

  lra_sqrt_pipe u_sqrt_pred (
    .clk  (clk),
    .en   (en),
    .x_in (sp3_r),
    .root (pr_root)
  );

  lra_sqrt_pipe u_sqrt_truth (
    .clk  (clk),
    .en   (en),
    .x_in (sg3_r),
    .root (gt_root)
  );

  logic signed [DOTW-1:0] dotd_r [RW];

  always_ff @(posedge clk) begin
    if (en) begin
      dotd_r[0] <= dot3_r;
      for (int i = 1; i < RW; i++) dotd_r[i] <= dotd_r[i-1];
    end
  end

  // ranges floored at one lsb
  logic [RW-1:0]   gt_a, pr_a;
  logic [RW-1:0]   gtA_r, prA_r, dfA_r;
  logic [SUMW-1:0] dmagA_r;
  logic            dposA_r;
  logic signed [DOTW-1:0] dot_neg;

  always_comb begin
    gt_a    = (gt_root == '0) ? RW'(1) : gt_root;
    pr_a    = (pr_root == '0) ? RW'(1) : pr_root;
    dot_neg = -dotd_r[RW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gtA_r   <= gt_a;
      prA_r   <= pr_a;
      dfA_r   <= (pr_a >= gt_a) ? (pr_a - gt_a) : (gt_a - pr_a);
      dposA_r <= (dotd_r[RW-1] > 0);
      dmagA_r <= dotd_r[RW-1][DOTW-1] ? dot_neg[SUMW-1:0] : dotd_r[RW-1][SUMW-1:0];
    end
  end

  logic [SUMW-1:0]      gtprB_r, gtgtB_r, gtdfB_r, dmagB_r;
  logic [FRAC_W+RW-1:0] ftolB_r;
  logic [RW-1:0]        gtB_r;
  logic                 dposB_r;

  always_ff @(posedge clk) begin
    if (en) begin
      gtprB_r <= gtA_r * prA_r;
      gtgtB_r <= gtA_r * gtA_r;
      gtdfB_r <= gtA_r * dfA_r;
      ftolB_r <= frac_r * gtA_r;
      gtB_r   <= gtA_r;
      dmagB_r <= dmagA_r;
      dposB_r <= dposA_r;
    end
  end

  // projected range error and tolerance
  logic [SUMW-1:0] en_c;
  logic [TW-1:0]   tol_c;
  logic [TW-1:0]   ftol_c;
  logic [EW-1:0]   enC_r;
  logic [TW-1:0]   tolC_r;
  logic [RW-1:0]   gtC_r;

  always_comb begin
    if (!dposB_r) begin
      en_c = gtgtB_r;
    end else if (dmagB_r >= gtprB_r) begin
      en_c = gtdfB_r;
    end else begin
      en_c = (dmagB_r >= gtgtB_r) ? (dmagB_r - gtgtB_r) : (gtgtB_r - dmagB_r);
    end
    ftol_c = TW'(ftolB_r[FRAC_W+RW-1:FRAC_W]);
    tol_c  = (ftol_c < TW'(mint_r)) ? TW'(mint_r) : ftol_c;
    if (tol_c == '0) tol_c = TW'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      enC_r  <= EW'(en_c);
      tolC_r <= tol_c;
      gtC_r  <= gtB_r;
    end
  end

  logic [EW-1:0]   enD_r;
  logic [DENW-1:0] denD_r;

  always_ff @(posedge clk) begin
    if (en) begin
      enD_r  <= enC_r;
      denD_r <= gtC_r * tolC_r;
    end
  end

  logic          div_ge;
  logic [QW-1:0] div_q;

  lra_div_pipe u_div (
    .clk    (clk),
    .en     (en),
    .num_in (enD_r),
    .den_in (EW'(denD_r)),
    .ge     (div_ge),
    .quo    (div_q)
  );

  logic [AFW-1:0] aff_r;

  always_ff @(posedge clk) begin
    if (en) begin
      aff_r <= div_ge ? '0 : ((AFW'(1) << QW) - AFW'(div_q));
    end
  end

  assign out_valid    = vld_r[LAT-1];
  assign out_affinity = aff_r;

  a_aff_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_affinity <= (AFW'(1) << QW)))
    else $error("affinity above one");

  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_affinity)))
    else $error("stalled result not held");

  a_in_halt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while output stalled");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import lra_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DRAIN = 60;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef logic signed [CW-1:0] coord_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_pred_x = '0, in_pred_y = '0, in_pred_z = '0;
  coord_t in_truth_x = '0, in_truth_y = '0, in_truth_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [AFW-1:0] out_affinity;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // mirror of the block's registers
  coord_t sensor_pos [3];
  logic [FRAC_W-1:0] tol_fraction = TOL_FRAC_RESET;
  logic [MINTOL_W-1:0] min_tolerance = MIN_TOL_RESET;

  logic [AFW-1:0] pending_affinity [$];
  int errors = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int zero_results = 0;
  int full_results = 0;
  int cfg_writes = 0;
  bit calm = 1'b0;
  int hold_ticket = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  localization_range_affinity_core DUT (.*);

  always #6 clk = ~clk;

  function automatic longint floor_sqrt(input logic [127:0] v);
    logic [127:0] r;
    logic [127:0] c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= v) r = c;
    end
    return (r == 0) ? 1 : longint'(r);
  endfunction

  function automatic logic [AFW-1:0] range_affinity(input coord_t p [3], input coord_t t [3]);
    longint pd [3];
    longint gd [3];
    logic signed [127:0] dot;
    logic [127:0] dot_mag, psq, gsq, en, den, gp, gg, q;
    longint pr, gt, tol;
    dot = 0;
    psq = 0;
    gsq = 0;
    for (int i = 0; i < 3; i++) begin
      pd[i] = longint'(p[i]) - longint'(sensor_pos[i]);
      gd[i] = longint'(t[i]) - longint'(sensor_pos[i]);
      dot += 128'(pd[i]) * 128'(gd[i]);
      psq += 128'(pd[i] * pd[i]);
      gsq += 128'(gd[i] * gd[i]);
    end
    dot_mag = (dot < 0) ? -dot : dot;
    pr = floor_sqrt(psq);
    gt = floor_sqrt(gsq);
    gp = 128'(gt) * 128'(pr);
    gg = 128'(gt) * 128'(gt);
    if (dot <= 0) en = gg;
    else if (dot_mag >= gp) en = 128'(gt) * 128'((pr >= gt) ? pr - gt : gt - pr);
    else en = (dot_mag >= gg) ? dot_mag - gg : gg - dot_mag;
    tol = (longint'(tol_fraction) * gt) >>> 16;
    if (tol < longint'(min_tolerance)) tol = longint'(min_tolerance);
    if (tol == 0) tol = 1;
    den = 128'(gt) * 128'(tol);
    if (en >= den) return '0;
    q = (en << AFFINITY_FRAC_BITS) / den;
    return AFW'((128'd1 << AFFINITY_FRAC_BITS) - q);
  endfunction

  // requests accepted at the input get their prediction
  always @(posedge clk) begin
    coord_t p [3];
    coord_t t [3];
    if (rst_n && in_valid && !in_stall) begin
      p = '{in_pred_x, in_pred_y, in_pred_z};
      t = '{in_truth_x, in_truth_y, in_truth_z};
      pending_affinity.push_back(range_affinity(p, t));
      requests_sent++;
    end
  end

  always @(posedge clk) begin
    logic [AFW-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_affinity == 0) zero_results++;
      if (out_affinity == AFW'(1 << AFFINITY_FRAC_BITS)) full_results++;
      if (pending_affinity.size() == 0) begin
        $error("affinity: result with nothing expected, actual %0d", out_affinity);
        errors++;
      end else begin
        want = pending_affinity.pop_front();
        if (out_affinity !== want) begin
          $error("affinity: expected %0d actual %0d", want, out_affinity);
          errors++;
        end
      end
    end
  end

  // receiver stall, with long hold-offs on request
  always @(posedge clk) begin
    if (hold_ticket != hold_served) begin
      hold_served <= hold_ticket;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 23);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_pair(input coord_t p [3], input coord_t t [3]);
    if (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pred_x <= p[0];
    in_pred_y <= p[1];
    in_pred_z <= p[2];
    in_truth_x <= t[0];
    in_truth_y <= t[1];
    in_truth_z <= t[2];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_affinity.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_SENSOR_X: sensor_pos[0] = val;
      REG_SENSOR_Y: sensor_pos[1] = val;
      REG_SENSOR_Z: sensor_pos[2] = val;
      REG_TOL_FRAC: tol_fraction = val[FRAC_W-1:0];
      REG_MIN_TOL:  min_tolerance = val[MINTOL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_sensor(input coord_t x, input coord_t y, input coord_t z);
    write_reg(REG_SENSOR_X, x);
    write_reg(REG_SENSOR_Y, y);
    write_reg(REG_SENSOR_Z, z);
  endtask

  function automatic coord_t near_sensor(input int i, input int spread);
    return sensor_pos[i] + coord_t'($signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // mix of well-aimed predictions, nearby points and raw noise
  task automatic send_random();
    coord_t p [3];
    coord_t t [3];
    int kind;
    int spread;
    kind = $urandom_range(99);
    spread = 1 << $urandom_range(2, 22);
    for (int i = 0; i < 3; i++) begin
      if (kind < 15) begin
        p[i] = coord_t'($urandom);
        t[i] = coord_t'($urandom);
      end else begin
        t[i] = near_sensor(i, spread);
        if (kind < 70) p[i] = t[i] + coord_t'($signed($urandom_range(0, 64)) - 32);
        else if (kind < 85) p[i] = t[i] + coord_t'(($signed(t[i] - sensor_pos[i])) >>> 4);
        else p[i] = near_sensor(i, spread);
      end
    end
    send_pair(p, t);
  endtask

  task automatic test_directed();
    coord_t lo, hi;
    lo = {1'b1, {(CW-1){1'b0}}};
    hi = {1'b0, {(CW-1){1'b1}}};
    // both centres on the sensor
    send_pair('{0, 0, 0}, '{0, 0, 0});
    // exact match
    send_pair('{2560, -512, 77}, '{2560, -512, 77});
    // opposite directions
    send_pair('{-2560, 0, 0}, '{2560, 0, 0});
    // orthogonal
    send_pair('{0, 2560, 0}, '{2560, 0, 0});
    // same direction, longer and shorter
    send_pair('{2700, 0, 0}, '{2560, 0, 0});
    send_pair('{2400, 0, 0}, '{2560, 0, 0});
    // small angle, cosine below one
    send_pair('{2560, 40, 0}, '{2560, 0, 0});
    send_pair('{2560, 0, 300}, '{2560, 0, 0});
    // prediction on the sensor
    send_pair('{0, 0, 0}, '{0, 0, 900});
    // truth on the sensor
    send_pair('{5, 0, 0}, '{0, 0, 0});
    send_pair('{lo, lo, lo}, '{lo, lo, lo});
    send_pair('{hi, hi, hi}, '{hi, hi, hi});
    send_pair('{hi, hi, hi}, '{lo, lo, lo});
    send_pair('{lo, hi, lo}, '{hi, lo, hi});
    send_pair('{hi, 0, 0}, '{hi - 1000, 0, 0});
    send_pair('{-1, -1, -1}, '{1, 1, 1});
    drain();
  endtask

  task automatic test_register_extremes();
    coord_t lo, hi;
    lo = {1'b1, {(CW-1){1'b0}}};
    hi = {1'b0, {(CW-1){1'b1}}};
    set_sensor(hi, lo, hi);
    send_pair('{lo, hi, lo}, '{lo, hi, lo});
    send_pair('{lo, hi, lo}, '{hi, lo, hi});
    send_pair('{hi, lo, hi}, '{hi, lo, hi});
    for (int n = 0; n < 40; n++) send_random();
    // zero tolerance forced to one LSB
    write_reg(REG_TOL_FRAC, 0);
    write_reg(REG_MIN_TOL, 0);
    set_sensor(0, 0, 0);
    send_pair('{0, 0, 0}, '{0, 0, 0});
    send_pair('{1, 0, 0}, '{0, 0, 0});
    send_pair('{3, 4, 0}, '{3, 4, 0});
    for (int n = 0; n < 40; n++) send_random();
    write_reg(REG_TOL_FRAC, 16'hFFFF);
    write_reg(REG_MIN_TOL, 24'hFFFFFF);
    send_pair('{lo, lo, lo}, '{hi, hi, hi});
    for (int n = 0; n < 40; n++) send_random();
    write_reg(REG_TOL_FRAC, CFG_DATA_W'(TOL_FRAC_RESET));
    write_reg(REG_MIN_TOL, CFG_DATA_W'(MIN_TOL_RESET));
    drain();
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      set_sensor(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
      write_reg(REG_TOL_FRAC, CFG_DATA_W'($urandom_range(0, 65535)));
      write_reg(REG_MIN_TOL,
                (phase % 2) ? CFG_DATA_W'($urandom_range(0, 2048)) : CFG_DATA_W'($urandom));
      for (int n = 0; n < 130; n++) send_random();
    end
    drain();
  endtask

  task automatic test_back_pressure();
    hold_ticket++;
    for (int n = 0; n < 120; n++) send_random();
    // sender waits for every result before going on
    drain();
    for (int n = 0; n < 30; n++) send_random();
    drain();
  endtask

  task automatic test_full_rate();
    calm = 1'b1;
    for (int n = 0; n < 100; n++) send_random();
    calm = 1'b0;
    drain();
  endtask

  initial begin
    sensor_pos = '{0, 0, 0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_back_pressure();
    test_full_rate();
    test_random_settings();
    drain();
    $display("%0d pairs checked over %0d register writes", results_seen, cfg_writes);
    $display("results at zero: %0d, at full affinity: %0d", zero_results, full_results);
    if (errors == 0 && pending_affinity.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
